// ----- rtl/ultrasonic_echo_ranger_macros.svh -----
// Assertion macros shared by the ultrasonic echo ranger RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define UER_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UER_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/uer_pkg.sv -----
// Shared types and constants of the ultrasonic echo ranger.
// No dependencies; used by uer_avg_pipe, ultrasonic_echo_ranger and the testbench.
package uer_pkg;

    localparam int ADDR_W = 4;
    localparam int SUM_W  = 20;
    localparam int NUM_W  = 28;   // holds sum * 160
    localparam int DIST_W = 15;
    localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;

    localparam logic [9:0]  TRIGGER_TICKS_RST = 10'd20;
    localparam logic [15:0] WAIT_LIMIT_RST    = 16'd30000;
    localparam logic [15:0] TIMER_PERIOD_RST  = 16'd25000;

    typedef enum logic [1:0] {
        REG_TRIGGER_TICKS = 2'd0,
        REG_WAIT_LIMIT    = 2'd1,
        REG_TIMER_PERIOD  = 2'd2
    } uer_reg_t;

    typedef struct packed {
        logic kind;
        logic echo;
    } uer_in_t;

    typedef struct packed {
        logic              trig;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_q4;
    } uer_out_t;

    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
    } uer_flags_t;

endpackage

// ----- rtl/ultrasonic_echo_ranger.sv -----
// Ultrasonic time-of-flight ranging controller, top level.
// Depends on uer_pkg, uer_avg_pipe and ultrasonic_echo_ranger_macros.svh.
//
//  channel | ports                        | payload
//  --------+------------------------------+-------------------------------
//  input   | s_valid, s_ready, s_data     | uer_in_t  (kind, echo)
//  result  | m_valid, m_ready, m_data     | uer_out_t (trig, busy_res, done_res, distance_q4)
//  config  | psel, penable, pwrite, paddr | 3 x 32-bit registers at 0, 4, 8
//
// One item per cycle while m_ready does not stall the pipeline; every item yields
// exactly one result.
// The sequencer state updates at the accept edge; the average goes through a
// reciprocal multiply, a back-multiply and a one-step correction stage.
// Reset is synchronous; no clearing pass; s_ready is low during reset. A stall
// on m_ready backs up the four-entry pipeline before s_ready drops.
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger import uer_pkg::*; #(
    parameter int SAMPLES = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  uer_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output uer_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRIG  = 2'd1,
        PH_WAIT  = 2'd2,
        PH_COUNT = 2'd3
    } phase_t;

    logic [9:0]       trigger_ticks_reg;
    logic [15:0]      wait_limit_reg;
    logic [15:0]      timer_period_reg;

    phase_t           phase_reg, phase_next;
    logic [3:0]       sample_index_reg, sample_index_next;
    logic [15:0]      phase_ticks_reg, phase_ticks_next;
    logic [15:0]      echo_count_reg, echo_count_next;
    logic [SUM_W-1:0] count_sum_reg, count_sum_next;

    logic             accept;
    logic             done;
    logic             end_meas;
    logic [15:0]      ticks_inc;
    logic [16:0]      count_plus;
    logic [15:0]      count_inc;
    logic [3:0]       index_inc;
    uer_flags_t       flags;
    logic [NUM_W-1:0] num;

    assign pready = 1'b1;
    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            wait_limit_reg    <= WAIT_LIMIT_RST;
            timer_period_reg  <= TIMER_PERIOD_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_TRIGGER_TICKS: trigger_ticks_reg <= pwdata[9:0];
                REG_WAIT_LIMIT:    wait_limit_reg    <= pwdata[15:0];
                REG_TIMER_PERIOD:  timer_period_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TRIGGER_TICKS: prdata = {22'd0, trigger_ticks_reg};
            REG_WAIT_LIMIT:    prdata = {16'd0, wait_limit_reg};
            REG_TIMER_PERIOD:  prdata = {16'd0, timer_period_reg};
            default:           prdata = '0;
        endcase
    end

    assign ticks_inc  = phase_ticks_reg + 16'd1;
    assign count_plus = {1'b0, echo_count_reg} + 17'd1;
    assign count_inc  = (count_plus[16] ||
                         (timer_period_reg != 16'd0 &&
                          count_plus[15:0] >= timer_period_reg)) ? 16'd0 : count_plus[15:0];
    assign index_inc  = sample_index_reg + 4'd1;

    always_comb begin
        phase_next        = phase_reg;
        sample_index_next = sample_index_reg;
        phase_ticks_next  = phase_ticks_reg;
        echo_count_next   = echo_count_reg;
        count_sum_next    = count_sum_reg;
        end_meas          = 1'b0;
        done              = 1'b0;

        if (s_data.kind) begin
            if (phase_reg == PH_IDLE) begin
                sample_index_next = '0;
                count_sum_next    = '0;
                phase_next        = PH_TRIG;
                phase_ticks_next  = '0;
                echo_count_next   = '0;
            end
        end else begin
            case (phase_reg)
                PH_TRIG: begin
                    phase_ticks_next = ticks_inc;
                    if (ticks_inc >= {6'd0, trigger_ticks_reg}) begin
                        phase_next       = PH_WAIT;
                        phase_ticks_next = '0;
                    end
                end
                PH_WAIT: begin
                    if (s_data.echo || phase_ticks_reg >= wait_limit_reg) begin
                        phase_next       = PH_COUNT;
                        phase_ticks_next = '0;
                        echo_count_next  = '0;
                    end else begin
                        phase_ticks_next = ticks_inc;
                    end
                end
                PH_COUNT: begin
                    if (!s_data.echo) begin
                        end_meas = 1'b1;
                    end else begin
                        echo_count_next = count_inc;
                        if (phase_ticks_reg >= wait_limit_reg) begin
                            end_meas = 1'b1;
                        end else begin
                            phase_ticks_next = ticks_inc;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (end_meas) begin
            count_sum_next    = count_sum_reg + SUM_W'(echo_count_next);
            sample_index_next = index_inc;
            phase_ticks_next  = '0;
            if (index_inc >= 4'(SAMPLES)) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
            end else begin
                phase_next      = PH_TRIG;
                echo_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            sample_index_reg <= '0;
            phase_ticks_reg  <= '0;
            echo_count_reg   <= '0;
            count_sum_reg    <= '0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            sample_index_reg <= sample_index_next;
            phase_ticks_reg  <= phase_ticks_next;
            echo_count_reg   <= echo_count_next;
            count_sum_reg    <= count_sum_next;
        end
    end

    assign flags.trig = (phase_next == PH_TRIG);
    assign flags.busy = (phase_next != PH_IDLE);
    assign flags.done = done;
    assign num        = (NUM_W'(count_sum_next) << 7) + (NUM_W'(count_sum_next) << 5);

    uer_avg_pipe #(
        .SAMPLES (SAMPLES)
    ) u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_flags  (flags),
        .in_num    (num),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    `UER_ASSERT_NXT(a_start_enters_trig, aclk, aresetn,
        accept && s_data.kind && phase_reg == PH_IDLE, phase_reg == PH_TRIG,
        "start while idle did not enter trigger phase")
    `UER_ASSERT_IMP(a_idle_ticks_clear, aclk, aresetn,
        phase_reg == PH_IDLE, phase_ticks_reg == 16'd0,
        "phase tick counter not cleared while idle")
    `UER_ASSERT_IMP(a_done_not_busy, aclk, aresetn,
        m_valid && m_data.done_res, !m_data.busy_res && !m_data.trig,
        "done item reports busy or trigger")
    `UER_ASSERT_IMP(a_dist_only_done, aclk, aresetn,
        m_valid && !m_data.done_res, m_data.distance_q4 == '0,
        "distance nonzero on an item that is not done")

endmodule

// ----- rtl/uer_avg_pipe.sv -----
// Result pipeline: registers item flags and divides sum*160 by 583*SAMPLES.
// Depends on uer_pkg; instantiated by ultrasonic_echo_ranger.
module uer_avg_pipe import uer_pkg::*; #(
    parameter int SAMPLES = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  uer_flags_t       in_flags,
    input  logic [NUM_W-1:0] in_num,
    output logic             out_valid,
    input  logic             out_ready,
    output uer_out_t         out_data
);

    localparam int      DIV     = 583 * SAMPLES;
    localparam int      DIV_W   = $clog2(DIV + 1);
    localparam int      SHIFT   = NUM_W;
    localparam longint  RECIP   = (64'd1 << SHIFT) / DIV;
    localparam int      RECIP_W = $clog2(RECIP + 1);
    localparam int      Q_W     = RECIP_W + 1;
    localparam int      PROD_W  = NUM_W + RECIP_W;
    localparam int      QD_W    = Q_W + DIV_W;

    logic             v1_reg, v2_reg, v3_reg, vo_reg;
    uer_flags_t       f1_reg, f2_reg, f3_reg;
    logic [NUM_W-1:0] n1_reg, n2_reg, n3_reg;
    logic [Q_W-1:0]   q2_reg, q3_reg;
    logic [NUM_W-1:0] qd3_reg;
    uer_out_t         out_reg;

    logic             rdy1, rdy2, rdy3, rdyo;
    logic [PROD_W-1:0] prod;
    logic [QD_W-1:0]  qd_full;
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   q_fin;
    logic [DIST_W-1:0] dist_sat;

    assign rdyo     = !vo_reg || out_ready;
    assign rdy3     = !v3_reg || rdyo;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1 && aresetn;

    assign prod     = PROD_W'(n1_reg) * PROD_W'(RECIP);
    assign qd_full  = QD_W'(q2_reg) * QD_W'(DIV);
    assign rem      = n3_reg - qd3_reg;
    assign q_fin    = (rem >= NUM_W'(DIV)) ? q3_reg + Q_W'(1) : q3_reg;
    assign dist_sat = (q_fin > Q_W'(DIST_MAX)) ? DIST_MAX : q_fin[DIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdyo) begin
                vo_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            f1_reg <= in_flags;
            n1_reg <= in_num;
        end
        if (rdy2 && v1_reg) begin
            f2_reg <= f1_reg;
            n2_reg <= n1_reg;
            q2_reg <= Q_W'(prod[PROD_W-1:SHIFT]);
        end
        if (rdy3 && v2_reg) begin
            f3_reg  <= f2_reg;
            n3_reg  <= n2_reg;
            q3_reg  <= q2_reg;
            qd3_reg <= qd_full[NUM_W-1:0];
        end
        if (rdyo && v3_reg) begin
            out_reg.trig        <= f3_reg.trig;
            out_reg.busy_res    <= f3_reg.busy;
            out_reg.done_res    <= f3_reg.done;
            out_reg.distance_q4 <= f3_reg.done ? dist_sat : '0;
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = out_reg;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for ultrasonic_echo_ranger: ranging sequences, register changes,
// back-pressure and random traffic, checked item by item against an in-bench predictor.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
module testbench;
    import uer_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOTS        = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_TRIGGER,
        SEQ_RISE_WAIT,
        SEQ_ECHO_COUNT
    } seq_phase_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    uer_in_t           s_data;
    logic              m_valid;
    logic              m_ready = 1'b0;
    uer_out_t          m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor: configuration and sequencer state
    logic [9:0]  cfg_trigger = TRIGGER_TICKS_RST;
    logic [15:0] cfg_wait    = WAIT_LIMIT_RST;
    logic [15:0] cfg_period  = TIMER_PERIOD_RST;
    seq_phase_t  seq_phase   = SEQ_IDLE;
    logic [3:0]  shot_idx    = '0;
    logic [15:0] phase_ticks = '0;
    logic [15:0] echo_ticks  = '0;
    logic [19:0] echo_sum    = '0;
    logic [14:0] last_dist   = '0;

    uer_out_t expected_results[$];

    int src_idle_pct = 10;
    int rcv_idle_pct = 20;
    int hold_left    = 0;
    int items_sent   = 0;
    int fail_count   = 0;
    int cycle_count  = 0;

    ultrasonic_echo_ranger #(.SAMPLES(SHOTS)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void start_shot();
        seq_phase   = SEQ_TRIGGER;
        phase_ticks = '0;
        echo_ticks  = '0;
    endfunction

    function automatic logic finish_shot();
        logic [63:0] avg;
        echo_sum = echo_sum + {4'd0, echo_ticks};
        shot_idx = shot_idx + 4'd1;
        if (shot_idx >= SHOTS) begin
            avg = ({44'd0, echo_sum} * 64'd160) / (64'd583 * SHOTS);
            last_dist   = (avg > {49'd0, DIST_MAX}) ? DIST_MAX : avg[14:0];
            seq_phase   = SEQ_IDLE;
            phase_ticks = '0;
            return 1'b1;
        end
        start_shot();
        return 1'b0;
    endfunction

    function automatic uer_out_t range_step(input uer_in_t it);
        uer_out_t    r;
        logic        done;
        logic [16:0] next_count;
        done = 1'b0;
        if (it.kind == KIND_START) begin
            if (seq_phase == SEQ_IDLE) begin
                shot_idx = '0;
                echo_sum = '0;
                start_shot();
            end
        end else begin
            case (seq_phase)
                SEQ_IDLE: ;
                SEQ_TRIGGER: begin
                    phase_ticks = phase_ticks + 16'd1;
                    if (phase_ticks >= {6'd0, cfg_trigger}) begin
                        seq_phase   = SEQ_RISE_WAIT;
                        phase_ticks = '0;
                    end
                end
                SEQ_RISE_WAIT: begin
                    if (it.echo || phase_ticks >= cfg_wait) begin
                        seq_phase   = SEQ_ECHO_COUNT;
                        phase_ticks = '0;
                        echo_ticks  = '0;
                    end else begin
                        phase_ticks = phase_ticks + 16'd1;
                    end
                end
                SEQ_ECHO_COUNT: begin
                    if (!it.echo) begin
                        done = finish_shot();
                    end else begin
                        next_count = {1'b0, echo_ticks} + 17'd1;
                        if (next_count[16] || (cfg_period != 16'd0 && next_count >= {1'b0, cfg_period}))
                            echo_ticks = '0;
                        else
                            echo_ticks = next_count[15:0];
                        if (phase_ticks >= cfg_wait)
                            done = finish_shot();
                        else
                            phase_ticks = phase_ticks + 16'd1;
                    end
                end
                default: seq_phase = SEQ_IDLE;
            endcase
        end
        r.trig        = (seq_phase == SEQ_TRIGGER);
        r.busy_res    = (seq_phase != SEQ_IDLE);
        r.done_res    = done;
        r.distance_q4 = done ? last_dist : '0;
        return r;
    endfunction

    task automatic send_item(input logic kind, input logic echo_lvl);
        uer_in_t it;
        logic    ignored;
        it.kind = kind;
        it.echo = echo_lvl;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        ignored = (kind == KIND_START) ? (seq_phase != SEQ_IDLE) : (seq_phase == SEQ_IDLE);
        if (!ignored)
            items_sent++;
        expected_results.push_back(range_step(it));
        @(posedge aclk);
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input uer_reg_t sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        case (sel)
            REG_TRIGGER_TICKS: cfg_trigger = value[9:0];
            REG_WAIT_LIMIT:    cfg_wait    = value[15:0];
            REG_TIMER_PERIOD:  cfg_period  = value[15:0];
            default: ;
        endcase
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // drives ticks shaped by the current phase, with occasional stray start items, until the sequence is over
    task automatic play_until_idle(input int rise_odds, input int fall_odds);
        int roll;
        while (seq_phase != SEQ_IDLE) begin
            roll = $urandom_range(99);
            if (roll < 2)
                send_item(KIND_START, 1'($urandom_range(0, 1)));
            else if (roll < 5)
                send_item(KIND_TICK, 1'($urandom_range(0, 1)));
            else begin
                case (seq_phase)
                    SEQ_RISE_WAIT:  send_item(KIND_TICK, $urandom_range(1, rise_odds) == 1);
                    SEQ_ECHO_COUNT: send_item(KIND_TICK, $urandom_range(1, fall_odds) != 1);
                    default:        send_item(KIND_TICK, 1'($urandom_range(0, 1)));
                endcase
            end
        end
    endtask

    task automatic run_sequence();
        repeat ($urandom_range(0, 2)) send_item(KIND_TICK, 1'($urandom_range(0, 1)));
        send_item(KIND_START, 1'($urandom_range(0, 1)));
        play_until_idle($urandom_range(1, 8), $urandom_range(2, 12));
    endtask

    task automatic randomize_registers();
        logic [31:0] noise;
        logic [9:0]  trig_val;
        logic [15:0] wait_val;
        logic [15:0] period_val;
        noise      = $urandom;
        trig_val   = ($urandom_range(7) == 0) ? 10'd0 : 10'($urandom_range(1, 12));
        wait_val   = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40));
        period_val = ($urandom_range(7) == 0) ? 16'd0 :
                     ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16));
        write_reg(REG_TRIGGER_TICKS, {noise[21:0], trig_val});
        write_reg(REG_WAIT_LIMIT, {noise[31:16], wait_val});
        write_reg(REG_TIMER_PERIOD, {noise[15:0], period_val});
    endtask

    task automatic test_reset_values();
        run_sequence();
        pause_until_drained();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_TRIGGER_TICKS, 32'd0);
        write_reg(REG_WAIT_LIMIT, 32'd0);
        write_reg(REG_TIMER_PERIOD, 32'd0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_START, 1'b1);
        send_item(KIND_START, 1'b0);
        for (int k = 0; k < SHOTS; k++) begin
            send_item(KIND_TICK, 1'($urandom_range(0, 1)));
            send_item(KIND_TICK, k[0]);
            send_item(KIND_TICK, k != SHOTS - 1);
        end
        pause_until_drained();
    endtask

    task automatic test_mid_run_writes();
        write_reg(REG_TRIGGER_TICKS, 32'd1023);
        write_reg(REG_WAIT_LIMIT, 32'd65535);
        write_reg(REG_TIMER_PERIOD, 32'd65535);
        send_item(KIND_START, 1'b0);
        repeat (30) send_item(KIND_TICK, 1'($urandom_range(0, 1)));
        pause_until_drained();
        write_reg(REG_TRIGGER_TICKS, 32'd2);
        send_item(KIND_TICK, 1'b0);
        repeat (5) send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
        repeat (12) send_item(KIND_TICK, 1'b1);
        pause_until_drained();
        // count now above the new period: next count wraps
        write_reg(REG_TIMER_PERIOD, 32'd5);
        repeat (4) send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        play_until_idle(4, 6);
        pause_until_drained();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(REG_TRIGGER_TICKS, 32'd3);
        write_reg(REG_WAIT_LIMIT, 32'd20);
        write_reg(REG_TIMER_PERIOD, 32'd0);
        @(negedge aclk);
        hold_left = 300;
        @(posedge aclk);
        run_sequence();
        run_sequence();
        pause_until_drained();
    endtask

    task automatic test_random_traffic(input int src_pct, input int rcv_pct, input int n_items);
        int goal;
        int seqs;
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        goal = items_sent + n_items;
        seqs = 0;
        while (items_sent < goal) begin
            if (seqs % 2 == 0) begin
                pause_until_drained();
                randomize_registers();
            end
            run_sequence();
            seqs++;
        end
        pause_until_drained();
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(negedge aclk) begin
        uer_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item %p", m_data);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.trig !== want.trig) begin
                    $error("trig: expected %0d, got %0d", want.trig, m_data.trig);
                    fail_count++;
                end
                if (m_data.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, m_data.busy_res);
                    fail_count++;
                end
                if (m_data.done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res, m_data.done_res);
                    fail_count++;
                end
                if (m_data.distance_q4 !== want.distance_q4) begin
                    $error("distance_q4: expected %0d, got %0d",
                           want.distance_q4, m_data.distance_q4);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("timeout after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_register_extremes();
        test_mid_run_writes();
        test_backpressure();
        test_random_traffic(29, 50, 620);
        test_random_traffic(50, 29, 620);
        test_random_traffic(0, 0, 620);

        if (expected_results.size() != 0) begin
            $error("%0d expected items never came out", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/uer_pkg.sv
rtl/uer_avg_pipe.sv
rtl/ultrasonic_echo_ranger.sv
sim/testbench.sv
